FILE: src/famd_pkg.sv
package famd_pkg;

    // field tracking codes
    typedef enum logic [1:0] {
        MK_NONE = 2'd0,
        MK_ID   = 2'd1,
        MK_GAP  = 2'd2,
        MK_DATA = 2'd3
    } mark_kind_t;

    // mark report codes
    typedef enum logic [1:0] {
        FOUND_NONE = 2'd0,
        FOUND_ID   = 2'd1,
        FOUND_DATA = 2'd2
    } found_t;

    localparam logic [7:0]  ID_MARK      = 8'hFE;
    localparam logic [7:0]  SYNC_MFM     = 8'hA1;
    localparam logic [7:0]  SYNC_FM      = 8'h00;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [10:0] ID_LEN       = 11'd6;
    localparam logic [10:0] GAP_FM       = 11'd30;
    localparam logic [10:0] GAP_MFM      = 11'd43;
    localparam logic [10:0] SECTOR_BASE  = 11'd128;
    localparam logic [10:0] CRC_LEN      = 11'd2;
    localparam logic [1:0]  SYNC_NEEDED  = 2'd3;

    // one byte of crc-16-ccitt, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // mfm preset: three sync bytes run over the initial value
    localparam logic [15:0] CRC_MFM_PRESET =
        crc_byte(crc_byte(crc_byte(CRC_INIT, SYNC_MFM), SYNC_MFM), SYNC_MFM);

    typedef struct packed {
        mark_kind_t  mark_kind;
        logic [10:0] field_count;
        logic [1:0]  sync_run;
        logic [15:0] crc_acc;
        logic [1:0]  sector_code;
    } famd_state_t;

endpackage

FILE: src/famd_crc.sv
module famd_crc (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [15:0] crc_out
);
    import famd_pkg::*;

    // byte-parallel crc step
    assign crc_out = crc_byte(crc_in, data_in);

endmodule

FILE: src/famd_step.sv
module famd_step (
    input  famd_pkg::famd_state_t cur,
    input  logic [7:0]            disk_byte,
    input  logic                  mfm,
    output famd_pkg::famd_state_t nxt,
    output famd_pkg::found_t      found
);
    import famd_pkg::*;

    mark_kind_t  mk_gap;
    logic [10:0] fc_gap;
    logic [10:0] fc_dec;
    logic        in_field;
    logic        data_ok;
    logic [7:0]  sync_byte;
    logic [15:0] crc_in;
    logic [15:0] crc_out;

    // gap countdown runs ahead of everything else
    always_comb begin
        mk_gap = cur.mark_kind;
        fc_gap = cur.field_count;
        if (cur.field_count != 11'd0 && cur.mark_kind == MK_GAP) begin
            fc_gap = cur.field_count - 11'd1;
            if (fc_gap == 11'd0) begin
                mk_gap = MK_NONE;
            end
        end
    end

    assign in_field  = (fc_gap != 11'd0) && (mk_gap != MK_GAP);
    assign fc_dec    = fc_gap - 11'd1;
    assign sync_byte = mfm ? SYNC_MFM : SYNC_FM;

    // data mark set depends on density
    always_comb begin
        if (mfm) begin
            data_ok = disk_byte inside {[8'hF8:8'hFF]};
        end else begin
            data_ok = disk_byte inside {[8'hF8:8'hFB]};
        end
    end

    // shared crc unit: running value inside a field, preset at a mark
    assign crc_in = in_field ? cur.crc_acc : (mfm ? CRC_MFM_PRESET : CRC_INIT);

    famd_crc u_crc (
        .crc_in  (crc_in),
        .data_in (disk_byte),
        .crc_out (crc_out)
    );

    // field walk, mark detection and sync counting
    always_comb begin
        nxt             = cur;
        nxt.mark_kind   = mk_gap;
        nxt.field_count = fc_gap;
        found           = FOUND_NONE;
        if (in_field) begin
            if (fc_gap > CRC_LEN) begin
                nxt.crc_acc = crc_out;
            end
            nxt.field_count = fc_dec;
            if (mk_gap == MK_ID && fc_dec == CRC_LEN) begin
                nxt.sector_code = disk_byte[1:0];
            end
            if (fc_dec == 11'd0) begin
                if (mk_gap == MK_ID) begin
                    nxt.mark_kind   = MK_GAP;
                    nxt.field_count = mfm ? GAP_MFM : GAP_FM;
                end else begin
                    nxt.mark_kind = MK_NONE;
                end
            end
        end else if (mk_gap != MK_GAP && mk_gap != MK_DATA &&
                     cur.sync_run == SYNC_NEEDED && disk_byte == ID_MARK) begin
            nxt.mark_kind   = MK_ID;
            nxt.field_count = ID_LEN;
            nxt.crc_acc     = crc_out;
            nxt.sync_run    = 2'd0;
            found           = FOUND_ID;
        end else if (mk_gap == MK_GAP && cur.sync_run == SYNC_NEEDED && data_ok) begin
            nxt.mark_kind   = MK_DATA;
            nxt.field_count = (SECTOR_BASE << cur.sector_code) + CRC_LEN;
            nxt.crc_acc     = crc_out;
            nxt.sync_run    = 2'd0;
            found           = FOUND_DATA;
        end else if (disk_byte == sync_byte) begin
            if (cur.sync_run != SYNC_NEEDED) begin
                nxt.sync_run = cur.sync_run + 2'd1;
            end
        end else begin
            nxt.sync_run = 2'd0;
        end
    end

endmodule

FILE: src/floppy_address_mark_detector_core.sv
// floppy address mark detector core
// input channel s_*: one decoded disk byte per beat (s_disk_byte).
// result channel m_*: one result beat per input beat, in order, giving the
// field state, bytes left, running crc-16-ccitt, captured size code and
// whether an id or data mark sat on that byte.
// cfg_we / cfg_wdata write density_mode (0 fm, 1 mfm); write only while idle.
// an accepted byte is held in the input register; its result is registered
// in the result register once that register is free, which raises m_valid.
// throughput is one byte per cycle while m_ready stays high; the state
// update is combinational (byte-parallel crc plus small counters).
// reset (aresetn low, synchronous) empties both stages, selects fm, clears
// the field state, counters and size code and sets the crc to 0xffff.
// when the receiver stalls the result register holds its beat; the input
// register still takes one more byte, then s_ready drops until m_ready
// returns. no beat is lost or repeated.
module floppy_address_mark_detector_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_disk_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_field_state,
    output logic [10:0] m_bytes_left,
    output logic [15:0] m_crc_value,
    output logic [1:0]  m_size_code,
    output logic [1:0]  m_mark_found
);
    import famd_pkg::*;

    logic        density_mode_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    famd_state_t state_reg;
    famd_state_t state_next;
    found_t      found_next;
    famd_state_t out_state_reg;
    found_t      out_found_reg;
    logic        out_free;
    logic        advance;

    // handshake between the two stages
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            density_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            density_mode_reg <= cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_disk_byte;
        end
    end

    // next field state from the held byte
    famd_step u_step (
        .cur       (state_reg),
        .disk_byte (in_byte_reg),
        .mfm       (density_mode_reg),
        .nxt       (state_next),
        .found     (found_next)
    );

    // tracking state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mark_kind   <= MK_NONE;
            state_reg.field_count <= 11'd0;
            state_reg.sync_run    <= 2'd0;
            state_reg.crc_acc     <= CRC_INIT;
            state_reg.sector_code <= 2'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_state_reg <= state_next;
            out_found_reg <= found_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_field_state = out_state_reg.mark_kind;
    assign m_bytes_left  = out_state_reg.field_count;
    assign m_crc_value   = out_state_reg.crc_acc;
    assign m_size_code   = out_state_reg.sector_code;
    assign m_mark_found  = out_found_reg;

endmodule

FILE: test/tb_floppy_address_mark_detector_core.sv
`timescale 1ns / 100ps

module tb_floppy_address_mark_detector_core;
    import famd_pkg::*;

    localparam int         DIR_N          = 20;
    localparam int         N_PHASES       = 5;
    localparam int         PHASE_ITEMS    = 80;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         HOLD_AT_ITEM   = 170;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         TIMEOUT_NS     = 2_000_000;
    localparam logic       DENS_FM        = 1'b0;
    localparam logic       DENS_MFM       = 1'b1;
    localparam logic [7:0] DMARK_LO       = 8'hF8;
    localparam logic [7:0] FM_DMARK_END   = 8'hFC;
    localparam logic [7:0] MFM_NOT_DMARK  = 8'hF0;

    localparam logic PHASE_DENSITY [N_PHASES] = '{DENS_FM, DENS_MFM, DENS_MFM, DENS_FM, DENS_MFM};

    typedef struct packed {
        mark_kind_t  field_state;
        logic [10:0] bytes_left;
        logic [15:0] crc_value;
        logic [1:0]  size_code;
        found_t      mark_found;
    } field_report_t;

    typedef struct packed {
        logic          pinned;
        field_report_t want;
    } pin_t;

    typedef struct packed {
        logic [7:0]    disk_byte;
        logic          pinned;
        field_report_t want;
    } dir_row_t;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_BUSY,
        RX_CHOKED
    } rx_mode_t;

    // searching, nothing captured yet
    localparam field_report_t IDLE_REPORT = '{MK_NONE, 11'd0, CRC_INIT, 2'd0, FOUND_NONE};

    // fm walk: sync run, id field, gap with a rejected mark, data mark
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{8'hFF, 1'b1, IDLE_REPORT},
        '{8'h00, 1'b1, IDLE_REPORT},
        '{8'h00, 1'b1, IDLE_REPORT},
        '{8'h00, 1'b1, IDLE_REPORT},
        '{8'h00, 1'b1, IDLE_REPORT},
        '{8'hFE, 1'b0, IDLE_REPORT},
        '{8'h00, 1'b0, IDLE_REPORT},
        '{8'hFF, 1'b0, IDLE_REPORT},
        '{8'h01, 1'b0, IDLE_REPORT},
        '{8'hFC, 1'b0, IDLE_REPORT},
        '{8'h12, 1'b0, IDLE_REPORT},
        '{8'h34, 1'b0, IDLE_REPORT},
        '{8'h00, 1'b0, IDLE_REPORT},
        '{8'h00, 1'b0, IDLE_REPORT},
        '{8'h00, 1'b0, IDLE_REPORT},
        '{8'hFC, 1'b0, IDLE_REPORT},
        '{8'h00, 1'b0, IDLE_REPORT},
        '{8'h00, 1'b0, IDLE_REPORT},
        '{8'h00, 1'b0, IDLE_REPORT},
        '{8'hFB, 1'b0, IDLE_REPORT}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_disk_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_field_state;
    logic [10:0] m_bytes_left;
    logic [15:0] m_crc_value;
    logic [1:0]  m_size_code;
    logic [1:0]  m_mark_found;

    // tracker copy of the block state
    mark_kind_t  kind_q    = MK_NONE;
    logic [10:0] count_q   = '0;
    logic [1:0]  sync_q    = '0;
    logic [15:0] crc_q     = CRC_INIT;
    logic [1:0]  size_q    = '0;
    logic        density_q = DENS_FM;

    field_report_t reports_due [$];
    pin_t          pin_q [$];
    logic [7:0]    byte_backlog [$];

    int            err_cnt      = 0;
    int            accepted_cnt = 0;
    int            burst_left   = 0;
    logic          chain_id     = 1'b0;
    field_report_t predicted;
    field_report_t due;
    pin_t          pin_now;

    floppy_address_mark_detector_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_disk_byte   (s_disk_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_state (m_field_state),
        .m_bytes_left  (m_bytes_left),
        .m_crc_value   (m_crc_value),
        .m_size_code   (m_size_code),
        .m_mark_found  (m_mark_found)
    );

    always #5 aclk = ~aclk;

    // crc-16-ccitt, one bit at a time, msb first
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // crc seed for a new field, mfm runs the three sync bytes first
    function automatic logic [15:0] crc_open(input logic [7:0] mark, input logic mfm);
        logic [15:0] c;
        c = CRC_INIT;
        if (mfm) begin
            for (int i = 0; i < 3; i++) c = crc_ccitt_step(c, SYNC_MFM);
        end
        return crc_ccitt_step(c, mark);
    endfunction

    // advance the tracker by one disk byte and report its state
    function automatic field_report_t track_byte(input logic [7:0] b);
        field_report_t r;
        logic          mfm;
        logic          data_ok;
        found_t        found;
        mfm   = density_q;
        found = FOUND_NONE;

        // gap countdown runs first, may hand back to searching
        if (count_q != 0 && kind_q == MK_GAP) begin
            count_q = count_q - 11'd1;
            if (count_q == 0) kind_q = MK_NONE;
        end

        data_ok = mfm ? (b >= DMARK_LO) : (b >= DMARK_LO && b < FM_DMARK_END);

        if (count_q != 0 && kind_q != MK_GAP) begin
            // inside an id or data field, crc bytes left out
            if (count_q > CRC_LEN) crc_q = crc_ccitt_step(crc_q, b);
            count_q = count_q - 11'd1;
            if (kind_q == MK_ID && count_q == CRC_LEN) size_q = b[1:0];
            if (count_q == 0) begin
                if (kind_q == MK_ID) begin
                    kind_q  = MK_GAP;
                    count_q = mfm ? GAP_MFM : GAP_FM;
                end else begin
                    kind_q = MK_NONE;
                end
            end
        end else if (kind_q != MK_GAP && kind_q != MK_DATA && sync_q == SYNC_NEEDED &&
                     b == ID_MARK) begin
            kind_q  = MK_ID;
            count_q = ID_LEN;
            crc_q   = crc_open(b, mfm);
            sync_q  = '0;
            found   = FOUND_ID;
        end else if (kind_q == MK_GAP && sync_q == SYNC_NEEDED && data_ok) begin
            kind_q  = MK_DATA;
            count_q = (SECTOR_BASE << size_q) + CRC_LEN;
            crc_q   = crc_open(b, mfm);
            sync_q  = '0;
            found   = FOUND_DATA;
        end else if (b == (mfm ? SYNC_MFM : SYNC_FM)) begin
            if (sync_q < SYNC_NEEDED) sync_q = sync_q + 2'd1;
        end else begin
            sync_q = '0;
        end

        r.field_state = kind_q;
        r.bytes_left  = count_q;
        r.crc_value   = crc_q;
        r.size_code   = size_q;
        r.mark_found  = found;
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // size code, mostly small so data fields stay short
    function automatic logic [1:0] pick_size_code();
        int r;
        r = $urandom_range(0, 15);
        if (r < 9) return 2'd0;
        if (r < 12) return 2'd1;
        if (r < 15) return 2'd2;
        return 2'd3;
    endfunction

    // data mark, now and then one the current density rejects
    function automatic logic [7:0] pick_data_mark();
        logic broken;
        broken = ($urandom_range(0, 7) == 0);
        if (density_q == DENS_MFM) begin
            return broken ? MFM_NOT_DMARK + 8'($urandom_range(0, 7))
                          : DMARK_LO + 8'($urandom_range(0, 7));
        end
        return broken ? FM_DMARK_END + 8'($urandom_range(0, 3))
                      : DMARK_LO + 8'($urandom_range(0, 3));
    endfunction

    // noise biased toward sync and mark values
    function automatic logic [7:0] pick_noise(input logic [7:0] sync_b);
        int r;
        r = $urandom_range(0, 7);
        if (r < 2) return sync_b;
        if (r == 2) return ID_MARK;
        if (r == 3) return DMARK_LO + 8'($urandom_range(0, 7));
        return rand_byte();
    endfunction

    // queue up one track record: noise, or id field then gap lapse or a sector
    task automatic build_record();
        int         kind;
        int         n;
        int         glen;
        logic [1:0] code;
        logic [7:0] sync_b;
        sync_b = density_q ? SYNC_MFM : SYNC_FM;
        glen   = density_q ? int'(GAP_MFM) : int'(GAP_FM);
        kind   = $urandom_range(0, 9);
        if (kind < 2) begin
            n = $urandom_range(4, 24);
            repeat (n) byte_backlog.push_back(pick_noise(sync_b));
            chain_id = 1'b0;
        end else begin
            // short preamble now and then, too few syncs for a mark
            if (!chain_id) begin
                n = (kind == 2) ? $urandom_range(0, 2) : $urandom_range(3, 6);
                repeat (n) byte_backlog.push_back(sync_b);
            end
            chain_id = 1'b0;
            byte_backlog.push_back(ID_MARK);
            repeat (3) byte_backlog.push_back(rand_byte());
            code = (kind < 5) ? 2'($urandom_range(0, 3)) : pick_size_code();
            byte_backlog.push_back({6'($urandom_range(0, 63)), code});
            repeat (2) byte_backlog.push_back(rand_byte());
            if (kind < 5) begin
                // gap runs out, next id mark lands on its last byte
                repeat (glen - 4) byte_backlog.push_back(rand_byte());
                repeat (3) byte_backlog.push_back(sync_b);
                chain_id = 1'b1;
            end else begin
                n = $urandom_range(0, glen - 5);
                repeat (n) byte_backlog.push_back(rand_byte());
                repeat (3) byte_backlog.push_back(sync_b);
                byte_backlog.push_back(pick_data_mark());
                repeat ((128 << code) + 2) byte_backlog.push_back(rand_byte());
            end
        end
    endtask

    // offer one byte in bursts with random gaps, return at its accepting edge
    task automatic send_byte(input logic [7:0] b, input logic pinned, input field_report_t want);
        int   gap;
        pin_t p;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        p.pinned = pinned;
        p.want   = want;
        pin_q.push_back(p);
        s_valid     <= 1'b1;
        s_disk_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop offering and wait until every report is back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_density(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        density_q = v;
    endtask

    task automatic check_field(input string what, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
            err_cnt++;
        end
    endtask

    // accepted bytes feed the tracker, result beats are checked in order
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = track_byte(s_disk_byte);
                accepted_cnt++;
                if (pin_q.size() != 0) begin
                    pin_now = pin_q.pop_front();
                    reports_due.push_back(pin_now.pinned ? pin_now.want : predicted);
                end else begin
                    reports_due.push_back(predicted);
                end
            end
            if (m_valid && m_ready) begin
                if (reports_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got state %0d left %0d",
                             $time, m_field_state, m_bytes_left);
                    err_cnt++;
                end else begin
                    due = reports_due.pop_front();
                    check_field("field_state", 16'(due.field_state), 16'(m_field_state));
                    check_field("bytes_left", 16'(due.bytes_left), 16'(m_bytes_left));
                    check_field("crc_value", due.crc_value, m_crc_value);
                    check_field("size_code", 16'(due.size_code), 16'(m_size_code));
                    check_field("mark_found", 16'(due.mark_found), 16'(m_mark_found));
                end
            end
        end
    end

    // receiver: stretches of free, busy and choked ready, one long hold-off
    initial begin
        rx_mode_t rx_mode;
        int       stretch_left;
        int       hold_left;
        logic     hold_done;
        rx_mode      = RX_FREE;
        stretch_left = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        m_ready      = 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && accepted_cnt >= HOLD_AT_ITEM) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (stretch_left == 0) begin
                    rx_mode      = rx_mode_t'($urandom_range(0, 2));
                    stretch_left = $urandom_range(16, 96);
                end
                stretch_left--;
                case (rx_mode)
                    RX_FREE: begin
                        m_ready <= 1'b1;
                    end
                    RX_BUSY: begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // stimulus: reset, directed fm walk, then random phases across densities
    initial begin
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = 1'b0;
        s_valid     = 1'b0;
        s_disk_byte = 8'h00;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_density(DENS_FM);

        for (int i = 0; i < DIR_N; i++) begin
            send_byte(DIR_ROWS[i].disk_byte, DIR_ROWS[i].pinned, DIR_ROWS[i].want);
        end

        // leftover bytes carry a field across a density change
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                settle();
                write_density(PHASE_DENSITY[ph]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (byte_backlog.size() == 0) build_record();
                send_byte(byte_backlog.pop_front(), 1'b0, IDLE_REPORT);
            end
        end
        // the rest of an unfinished record is not sent
        byte_backlog.delete();
        settle();

        if (err_cnt == 0 && reports_due.size() == 0) begin
            $display("tb_floppy_address_mark_detector_core: done, clean");
        end else begin
            $display("tb_floppy_address_mark_detector_core: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb_floppy_address_mark_detector_core: done, errors");
        $finish;
    end

endmodule
